// File: hw/rtl/mf3_pkg.sv
// mf3_pkg: shared types and constants of the 3x3 median filter
// used by mf3_median, median_filter_3x3_top and mf3_checker

package mf3_pkg;

  localparam int unsigned PixW     = 8;
  localparam int unsigned Taps     = 9;
  localparam int unsigned MaxWidth = 256;
  localparam int unsigned AddrW    = $clog2(MaxWidth);
  localparam int unsigned WidthW   = 9;
  localparam int unsigned HeightW  = 12;
  localparam int unsigned CfgW     = 12;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned ResetSize = 200;
  localparam int unsigned MinSize  = 3;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 2'd1;

  // result kinds, one bit each in the pending mask, emitted low bit first
  localparam int unsigned ResTop     = 0;  // first row, pixel itself
  localparam int unsigned ResLeft    = 1;  // row above, left border
  localparam int unsigned ResMedian  = 2;  // row above, interior median
  localparam int unsigned ResRight   = 3;  // row above, right border
  localparam int unsigned ResBottom  = 4;  // last row, pixel itself
  localparam int unsigned ResKinds   = 5;

  typedef logic [PixW-1:0] pix_t;
  typedef pix_t [Taps-1:0] taps_t;

  // compare-exchange: returns {max, min}
  function automatic logic [2*PixW-1:0] cas(pix_t a, pix_t b);
    logic [2*PixW-1:0] res;
    if (a > b) begin
      res = {a, b};
    end else begin
      res = {b, a};
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/median_filter_3x3_top.sv
// median_filter_3x3_top: 3x3 median filter over a raster pixel stream
// depends on mf3_pkg and mf3_median
//
//   port group   direction  beat carries
//   in_*         in         pixel_in
//   out_*        out        out_row, out_col, out_pixel, last_of_run, frame_done
//   cfg_*        in         register index and data, no handshake
//
// a pixel enters a work register whose line buffer reads are registered; its
// results pass to the result register. a pixel that causes k results holds the
// work register until its last is emitted (one result per beat on the single
// output register): one pixel per cycle where k <= 1 and the output is free.
// out_stall_i backs up through the output register into in_stall_o.
// reset clears control state and the window; the line buffers are not cleared.

module median_filter_3x3_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [mf3_pkg::PixW-1:0]       pixel_in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [mf3_pkg::HeightW-1:0]    out_row_o,
  output logic [mf3_pkg::AddrW-1:0]      out_col_o,
  output logic [mf3_pkg::PixW-1:0]       out_pixel_o,
  output logic                           last_of_run_o,
  output logic                           frame_done_o,
  input  logic                           cfg_we_i,
  input  logic [mf3_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [mf3_pkg::CfgW-1:0]       cfg_data_i
);

  localparam int unsigned AddrW   = mf3_pkg::AddrW;
  localparam int unsigned WidthW  = mf3_pkg::WidthW;
  localparam int unsigned HeightW = mf3_pkg::HeightW;
  localparam int unsigned Kinds   = mf3_pkg::ResKinds;

  // configuration and position
  logic [WidthW-1:0]  width_q;
  logic [HeightW-1:0] height_q;
  logic [HeightW-1:0] row_q, row_d;
  logic [AddrW-1:0]   col_q, col_d;
  logic [WidthW-1:0]  w_eff;
  logic [HeightW-1:0] h_eff;
  logic [HeightW-1:0] r_cur;
  logic [AddrW-1:0]   c_cur;
  logic               c_is_last;
  logic [Kinds-1:0]   mask_new;

  // line buffers
  mf3_pkg::pix_t line_older_q [mf3_pkg::MaxWidth];
  mf3_pkg::pix_t line_newer_q [mf3_pkg::MaxWidth];
  mf3_pkg::pix_t top_q, mid_q;

  // work register
  logic               s1_valid_q;
  logic [Kinds-1:0]   s1_mask_q, s1_mask_d;
  mf3_pkg::pix_t      s1_pix_q;
  logic [HeightW-1:0] s1_row_q, s1_rowm1_q;
  logic [AddrW-1:0]   s1_col_q, s1_colm1_q;
  logic               s1_lastcol_q;
  mf3_pkg::pix_t [5:0] window_q;
  mf3_pkg::taps_t     taps;
  mf3_pkg::pix_t      median;

  // result register
  logic               out_valid_q;
  logic [HeightW-1:0] out_row_q, res_row;
  logic [AddrW-1:0]   out_col_q, res_col;
  mf3_pkg::pix_t      out_pixel_q, res_pix;
  logic               out_last_q, res_last;
  logic               out_done_q, res_done;

  logic out_free, emit, s1_consume, accept;

  // effective frame size
  always_comb begin
    w_eff = width_q;
    if (width_q < WidthW'(mf3_pkg::MinSize)) begin
      w_eff = WidthW'(mf3_pkg::MinSize);
    end else if (width_q > WidthW'(mf3_pkg::MaxWidth)) begin
      w_eff = WidthW'(mf3_pkg::MaxWidth);
    end
    h_eff = height_q;
    if (height_q < HeightW'(mf3_pkg::MinSize)) begin
      h_eff = HeightW'(mf3_pkg::MinSize);
    end
  end

  // position of the incoming pixel and the results it will cause
  always_comb begin
    if ({1'b0, col_q} >= w_eff || row_q >= h_eff) begin
      r_cur = '0;
      c_cur = '0;
    end else begin
      r_cur = row_q;
      c_cur = col_q;
    end
    c_is_last = ({1'b0, c_cur} == w_eff - WidthW'(1));
    mask_new = '0;
    mask_new[mf3_pkg::ResTop]    = (r_cur == '0);
    mask_new[mf3_pkg::ResLeft]   = (r_cur >= HeightW'(2)) && (c_cur == '0);
    mask_new[mf3_pkg::ResMedian] = (r_cur >= HeightW'(2)) && (c_cur >= AddrW'(2));
    mask_new[mf3_pkg::ResRight]  = (r_cur >= HeightW'(2)) && c_is_last;
    mask_new[mf3_pkg::ResBottom] = (r_cur == h_eff - HeightW'(1));
    if ({1'b0, c_cur} + WidthW'(1) >= w_eff) begin
      col_d = '0;
      row_d = (r_cur + HeightW'(1) >= h_eff) ? '0 : r_cur + HeightW'(1);
    end else begin
      col_d = c_cur + AddrW'(1);
      row_d = r_cur;
    end
  end

  // handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit       = s1_valid_q && (s1_mask_q != '0) && out_free;
  assign s1_consume = s1_valid_q && ((s1_mask_q == '0) ||
                      (emit && ((s1_mask_q & (s1_mask_q - Kinds'(1))) == '0)));
  assign in_stall_o = s1_valid_q && !s1_consume;
  assign accept     = in_valid_i && !in_stall_o;

  // register file and position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthW'(mf3_pkg::ResetSize);
      height_q <= HeightW'(mf3_pkg::ResetSize);
      row_q    <= '0;
      col_q    <= '0;
    end else if (cfg_we_i && (cfg_index_i == mf3_pkg::RegFrameWidth ||
                              cfg_index_i == mf3_pkg::RegFrameHeight)) begin
      if (cfg_index_i == mf3_pkg::RegFrameWidth) begin
        width_q <= cfg_data_i[WidthW-1:0];
      end else begin
        height_q <= cfg_data_i[HeightW-1:0];
      end
      row_q <= '0;
      col_q <= '0;
    end else if (accept) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // line buffers: newer row written on accept, older row from the work register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      top_q <= line_older_q[c_cur];
      mid_q <= line_newer_q[c_cur];
      line_newer_q[c_cur] <= pixel_in_i;
    end
    if (s1_consume) begin
      line_older_q[s1_col_q] <= mid_q;
    end
  end

  // work register
  always_comb begin
    s1_mask_d = s1_mask_q;
    if (emit) begin
      s1_mask_d = s1_mask_q & (s1_mask_q - Kinds'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_mask_q  <= '0;
      window_q   <= '0;
    end else begin
      if (s1_consume) begin
        window_q <= {s1_pix_q, mid_q, top_q, window_q[5:3]};
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
        s1_mask_q  <= mask_new;
      end else begin
        if (s1_consume) begin
          s1_valid_q <= 1'b0;
        end
        s1_mask_q <= s1_mask_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q     <= pixel_in_i;
      s1_row_q     <= r_cur;
      s1_rowm1_q   <= r_cur - HeightW'(1);
      s1_col_q     <= c_cur;
      s1_colm1_q   <= c_cur - AddrW'(1);
      s1_lastcol_q <= c_is_last;
    end
  end

  assign taps = {s1_pix_q, mid_q, top_q, window_q};

  mf3_median u_median (
    .taps_i   (taps),
    .median_o (median)
  );

  // pick the lowest pending result
  always_comb begin
    res_row  = s1_rowm1_q;
    res_col  = s1_col_q;
    res_pix  = mid_q;
    res_done = 1'b0;
    res_last = ((s1_mask_q & (s1_mask_q - Kinds'(1))) == '0);
    if (s1_mask_q[mf3_pkg::ResTop]) begin
      res_row = s1_row_q;
      res_pix = s1_pix_q;
    end else if (s1_mask_q[mf3_pkg::ResLeft]) begin
      res_col = '0;
    end else if (s1_mask_q[mf3_pkg::ResMedian]) begin
      res_col = s1_colm1_q;
      res_pix = median;
    end else if (s1_mask_q[mf3_pkg::ResRight]) begin
      res_pix = mid_q;
    end else begin
      res_row  = s1_row_q;
      res_pix  = s1_pix_q;
      res_done = s1_lastcol_q;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_row_q   <= res_row;
      out_col_q   <= res_col;
      out_pixel_q <= res_pix;
      out_last_q  <= res_last;
      out_done_q  <= res_done;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_row_o     = out_row_q;
  assign out_col_o     = out_col_q;
  assign out_pixel_o   = out_pixel_q;
  assign last_of_run_o = out_last_q;
  assign frame_done_o  = out_done_q;

endmodule

// File: hw/rtl/mf3_median.sv
// mf3_median: fixed 19-exchange sorting network, median of nine pixels
// depends on mf3_pkg

module mf3_median (
  input  mf3_pkg::taps_t taps_i,
  output mf3_pkg::pix_t  median_o
);

  mf3_pkg::taps_t p;

  always_comb begin
    p = taps_i;
    {p[2], p[1]} = mf3_pkg::cas(p[1], p[2]);
    {p[5], p[4]} = mf3_pkg::cas(p[4], p[5]);
    {p[8], p[7]} = mf3_pkg::cas(p[7], p[8]);
    {p[1], p[0]} = mf3_pkg::cas(p[0], p[1]);
    {p[4], p[3]} = mf3_pkg::cas(p[3], p[4]);
    {p[7], p[6]} = mf3_pkg::cas(p[6], p[7]);
    {p[2], p[1]} = mf3_pkg::cas(p[1], p[2]);
    {p[5], p[4]} = mf3_pkg::cas(p[4], p[5]);
    {p[8], p[7]} = mf3_pkg::cas(p[7], p[8]);
    {p[3], p[0]} = mf3_pkg::cas(p[0], p[3]);
    {p[8], p[5]} = mf3_pkg::cas(p[5], p[8]);
    {p[7], p[4]} = mf3_pkg::cas(p[4], p[7]);
    {p[6], p[3]} = mf3_pkg::cas(p[3], p[6]);
    {p[4], p[1]} = mf3_pkg::cas(p[1], p[4]);
    {p[5], p[2]} = mf3_pkg::cas(p[2], p[5]);
    {p[7], p[4]} = mf3_pkg::cas(p[4], p[7]);
    {p[2], p[4]} = mf3_pkg::cas(p[4], p[2]);
    {p[4], p[6]} = mf3_pkg::cas(p[6], p[4]);
    {p[2], p[4]} = mf3_pkg::cas(p[4], p[2]);
  end

  assign median_o = p[4];

endmodule

// File: hw/rtl/mf3_checker.sv
// mf3_checker: port-level checks of the 3x3 median filter, bound to the top level
// depends on mf3_pkg and median_filter_3x3_top

module mf3_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [mf3_pkg::HeightW-1:0]    out_row_o,
  input logic [mf3_pkg::AddrW-1:0]      out_col_o,
  input logic [mf3_pkg::PixW-1:0]       out_pixel_o,
  input logic                           last_of_run_o,
  input logic                           frame_done_o
);

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_pixel_o) &&
    $stable(out_row_o) && $stable(out_col_o) && $stable(last_of_run_o))
    else $error("stalled output beat changed");

  // bottom-right pixel closes its run
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> last_of_run_o)
    else $error("frame_done without last_of_run");

  // bottom row is never row zero
  a_done_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> out_row_o >= mf3_pkg::HeightW'(2))
    else $error("frame_done on a row above the bottom");

  // a run continues without a gap once a beat is taken
  a_run_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_of_run_o |=> out_valid_o)
    else $error("gap inside a run of results");

endmodule

bind median_filter_3x3_top mf3_checker u_mf3_checker (.*);

// File: sim/tb_median_filter_3x3_top.sv
// tb_median_filter_3x3_top: self-checking testbench of the 3x3 median filter
// a predictor of the filter feeds a queue of awaited result beats; uses mf3_pkg
// and median_filter_3x3_top
`timescale 1ns / 1ps

module tb_median_filter_3x3_top;

  localparam logic [mf3_pkg::CfgIdxW-1:0] RegSpareA = 2'd2;
  localparam logic [mf3_pkg::CfgIdxW-1:0] RegSpareB = 2'd3;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned FlavorUniform = 0;
  localparam int unsigned FlavorExtreme = 2;
  localparam int unsigned FlavorNarrow = 3;

  typedef struct packed {
    logic [mf3_pkg::HeightW-1:0] row;
    logic [mf3_pkg::AddrW-1:0]   col;
    mf3_pkg::pix_t               pixel;
    logic                        last;
    logic                        done;
  } out_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  mf3_pkg::pix_t pixel_in_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [mf3_pkg::HeightW-1:0] out_row_o;
  logic [mf3_pkg::AddrW-1:0] out_col_o;
  mf3_pkg::pix_t out_pixel_o;
  logic last_of_run_o;
  logic frame_done_o;
  logic cfg_we_i = 1'b0;
  logic [mf3_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [mf3_pkg::CfgW-1:0] cfg_data_i = '0;

  logic steady = 1'b0;
  logic holding = 1'b0;

  // predictor state
  logic [mf3_pkg::WidthW-1:0] width_reg;
  logic [mf3_pkg::HeightW-1:0] height_reg;
  mf3_pkg::pix_t older_line [mf3_pkg::MaxWidth];
  mf3_pkg::pix_t newer_line [mf3_pkg::MaxWidth];
  mf3_pkg::pix_t win_cols [6];
  int unsigned next_row;
  int unsigned next_col;

  out_beat_t awaited_beats [$];
  int unsigned bad_beats = 0;

  median_filter_3x3_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pixel_in_i    (pixel_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_row_o     (out_row_o),
    .out_col_o     (out_col_o),
    .out_pixel_o   (out_pixel_o),
    .last_of_run_o (last_of_run_o),
    .frame_done_o  (frame_done_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic void reset_filter_model();
    width_reg = mf3_pkg::WidthW'(mf3_pkg::ResetSize);
    height_reg = mf3_pkg::HeightW'(mf3_pkg::ResetSize);
    foreach (older_line[i]) older_line[i] = '0;
    foreach (newer_line[i]) newer_line[i] = '0;
    foreach (win_cols[i]) win_cols[i] = '0;
    next_row = 0;
    next_col = 0;
  endfunction

  function automatic void apply_reg_write(logic [mf3_pkg::CfgIdxW-1:0] idx,
                                          logic [mf3_pkg::CfgW-1:0] data);
    case (idx)
      mf3_pkg::RegFrameWidth: begin
        width_reg = data[mf3_pkg::WidthW-1:0];
        next_row = 0;
        next_col = 0;
      end
      mf3_pkg::RegFrameHeight: begin
        height_reg = data[mf3_pkg::HeightW-1:0];
        next_row = 0;
        next_col = 0;
      end
      default: ;
    endcase
  endfunction

  function automatic mf3_pkg::pix_t window_median(mf3_pkg::pix_t v [9]);
    mf3_pkg::pix_t t;
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 8 - i; j++) begin
        if (v[j] > v[j+1]) begin
          t = v[j];
          v[j] = v[j+1];
          v[j+1] = t;
        end
      end
    end
    return v[4];
  endfunction

  function automatic void await_beat(int unsigned row, int unsigned col,
                                     mf3_pkg::pix_t pix, logic done);
    out_beat_t b;
    b.row = mf3_pkg::HeightW'(row);
    b.col = mf3_pkg::AddrW'(col);
    b.pixel = pix;
    b.last = 1'b0;
    b.done = done;
    awaited_beats = {awaited_beats, b};
  endfunction

  function automatic void filter_pixel(mf3_pkg::pix_t pix);
    int unsigned w, h, r, c, first;
    mf3_pkg::pix_t top, mid;
    mf3_pkg::pix_t taps [9];
    w = (width_reg < mf3_pkg::MinSize) ? mf3_pkg::MinSize :
        ((width_reg > mf3_pkg::MaxWidth) ? mf3_pkg::MaxWidth : width_reg);
    h = (height_reg < mf3_pkg::MinSize) ? mf3_pkg::MinSize : height_reg;
    r = next_row;
    c = next_col;
    if (c >= w || r >= h) begin
      r = 0;
      c = 0;
    end
    top = older_line[c];
    mid = newer_line[c];
    for (int i = 0; i < 6; i++) taps[i] = win_cols[i];
    taps[6] = top;
    taps[7] = mid;
    taps[8] = pix;
    first = awaited_beats.size();
    if (r == 0) await_beat(r, c, pix, 1'b0);
    if (r >= 2) begin
      if (c == 0) await_beat(r - 1, 0, mid, 1'b0);
      if (c >= 2) await_beat(r - 1, c - 1, window_median(taps), 1'b0);
      if (c == w - 1) await_beat(r - 1, c, mid, 1'b0);
    end
    if (r == h - 1) await_beat(r, c, pix, c == w - 1);
    if (awaited_beats.size() > first) awaited_beats[awaited_beats.size() - 1].last = 1'b1;
    older_line[c] = mid;
    newer_line[c] = pix;
    win_cols[0] = win_cols[3];
    win_cols[1] = win_cols[4];
    win_cols[2] = win_cols[5];
    win_cols[3] = top;
    win_cols[4] = mid;
    win_cols[5] = pix;
    if (c + 1 >= w) begin
      next_col = 0;
      next_row = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      next_col = c + 1;
      next_row = r;
    end
  endfunction

  function automatic void report_mismatch(string what, out_beat_t want, out_beat_t got);
    bad_beats++;
    if (bad_beats <= MaxReports) begin
      $display("%0t %s: expected row %0d col %0d pix %0d last %0b done %0b,",
               $time, what, want.row, want.col, want.pixel, want.last, want.done);
      $display("    got row %0d col %0d pix %0d last %0b done %0b",
               got.row, got.col, got.pixel, got.last, got.done);
    end
  endfunction

  // output beats are stable from the settle point to the accepting edge
  always @(negedge clk_i) begin
    out_beat_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {out_row_o, out_col_o, out_pixel_o, last_of_run_o, frame_done_o};
      if (awaited_beats.size() == 0) begin
        report_mismatch("unexpected beat", '0, got);
      end else begin
        want = awaited_beats.pop_front();
        if (got !== want) report_mismatch("wrong beat", want, got);
      end
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= holding || (!steady && ($urandom_range(99) < 24));
  end

  task automatic send_pixel(input mf3_pkg::pix_t pix);
    while (!steady && $urandom_range(99) < 24) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_in_i <= pix;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
    filter_pixel(pix);
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (awaited_beats.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [mf3_pkg::CfgIdxW-1:0] idx,
                           input logic [mf3_pkg::CfgW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    apply_reg_write(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic hold_receiver(input int unsigned cycles);
    holding <= 1'b1;
    repeat (cycles) @(posedge clk_i);
    holding <= 1'b0;
  endtask

  function automatic mf3_pkg::pix_t pick_pixel(int unsigned flavor);
    case (flavor)
      FlavorExtreme: return $urandom_range(1) ? 8'hFF : 8'h00;
      FlavorNarrow: return mf3_pkg::pix_t'($urandom_range(122, 118));
      default: return mf3_pkg::pix_t'($urandom);
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'h5A);
    wait_for_drain();
  endtask

  task automatic test_small_frame();
    mf3_pkg::pix_t frame [9];
    frame = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA, 8'hFF};
    write_reg(mf3_pkg::RegFrameWidth, 12'd3);
    write_reg(mf3_pkg::RegFrameHeight, 12'd3);
    foreach (frame[i]) send_pixel(frame[i]);
    wait_for_drain();
  endtask

  task automatic test_size_saturation();
    // a write mid-frame restarts the frame, spare indexes change nothing
    send_pixel(8'hFF);
    send_pixel(8'h00);
    wait_for_drain();
    write_reg(mf3_pkg::RegFrameWidth, 12'd1);
    write_reg(mf3_pkg::RegFrameHeight, 12'd0);
    repeat (4) send_pixel(pick_pixel(FlavorExtreme));
    wait_for_drain();
    write_reg(RegSpareA, 12'hFFF);
    write_reg(RegSpareB, 12'h0AA);
    repeat (5) send_pixel(pick_pixel(FlavorUniform));
    wait_for_drain();
  endtask

  task automatic test_random_frames();
    int unsigned w, h, wn, hn, flavor;
    repeat (4) begin
      w = ($urandom_range(9) < 2) ? $urandom_range(2) : $urandom_range(8, 3);
      h = ($urandom_range(9) < 2) ? $urandom_range(2) : $urandom_range(5, 3);
      wn = (w < mf3_pkg::MinSize) ? mf3_pkg::MinSize : w;
      hn = (h < mf3_pkg::MinSize) ? mf3_pkg::MinSize : h;
      wait_for_drain();
      write_reg(mf3_pkg::RegFrameWidth, {3'($urandom), 9'(w)});
      write_reg(mf3_pkg::RegFrameHeight, mf3_pkg::CfgW'(h));
      flavor = $urandom_range(3);
      repeat (wn * hn) send_pixel(pick_pixel(flavor));
      // broken frame, cut short by the next register write
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(12, 1)) send_pixel(pick_pixel(flavor));
      end
    end
    wait_for_drain();
  endtask

  task automatic test_backpressure();
    write_reg(mf3_pkg::RegFrameWidth, 12'd5);
    write_reg(mf3_pkg::RegFrameHeight, 12'd6);
    steady <= 1'b1;
    fork
      hold_receiver(300);
      repeat (60) send_pixel(pick_pixel(FlavorUniform));
    join
    steady <= 1'b0;
    repeat (10) send_pixel(pick_pixel(FlavorUniform));
    wait_for_drain();
    repeat (20) send_pixel(pick_pixel(FlavorUniform));
    wait_for_drain();
  endtask

  task automatic test_wide_frame();
    // one full row plus the start of the next, width saturates at the buffer depth
    write_reg(mf3_pkg::RegFrameWidth, 12'hFFF);
    write_reg(mf3_pkg::RegFrameHeight, 12'hFFF);
    repeat (mf3_pkg::MaxWidth + 4) send_pixel(pick_pixel(FlavorUniform));
    wait_for_drain();
  endtask

  initial begin
    reset_filter_model();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_small_frame();
    test_size_saturation();
    test_random_frames();
    test_backpressure();
    test_wide_frame();
    if (bad_beats == 0 && awaited_beats.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/mf3_pkg.sv
hw/rtl/mf3_median.sv
hw/rtl/median_filter_3x3_top.sv
hw/rtl/mf3_checker.sv
sim/tb_median_filter_3x3_top.sv
